[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define TCPO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true out of reset
`define TCPO_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[rtl/tcpo_pkg.sv]
// ---------------------------------------------------------------------------
// TCP option parser package
// Types and constants shared by the option parser core and its channels.
// ---------------------------------------------------------------------------
package tcpo_pkg;

   localparam int AREA_W  = 6;
   localparam int KIND_W  = 4;
   localparam int VALUE_W = 32;
   localparam int ACC_W   = 64;

   // Option kind bytes on the wire
   localparam logic [7:0] OPT_EOL    = 8'd0;
   localparam logic [7:0] OPT_NOP    = 8'd1;
   localparam logic [7:0] OPT_MSS    = 8'd2;
   localparam logic [7:0] OPT_WSCALE = 8'd3;
   localparam logic [7:0] OPT_SACKOK = 8'd4;
   localparam logic [7:0] OPT_SACK   = 8'd5;
   localparam logic [7:0] OPT_TSTAMP = 8'd8;

   // Total option lengths, kind and length bytes included
   localparam logic [AREA_W-1:0] LEN_MSS    = 6'd4;
   localparam logic [AREA_W-1:0] LEN_WSCALE = 6'd3;
   localparam logic [AREA_W-1:0] LEN_SACKOK = 6'd2;
   localparam logic [AREA_W-1:0] LEN_TSTAMP = 6'd10;
   localparam logic [AREA_W-1:0] LEN_HDR    = 6'd2;

   typedef enum logic [2:0] {
      PH_KIND,
      PH_SKIP_LEN,
      PH_VALUE,
      PH_SACK_LEN,
      PH_SACK_BLOCK,
      PH_SACK_SKIP
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      K_EOL        = 4'd0,
      K_NOP        = 4'd1,
      K_MSS        = 4'd2,
      K_WSCALE     = 4'd3,
      K_SACKOK     = 4'd4,
      K_SACK_HDR   = 4'd5,
      K_SACK_BLOCK = 4'd6,
      K_TSTAMP     = 4'd7,
      K_SACK_BAD   = 4'd8,
      K_TRUNCATED  = 4'd9,
      K_UNKNOWN    = 4'd10,
      K_DONE       = 4'd11
   } kind_type;

   typedef struct packed {
      kind_type           kind_code;
      logic [VALUE_W-1:0] value_a;
      logic [VALUE_W-1:0] value_b;
      logic               last_result;
   } result_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic              first_byte;
      logic [AREA_W-1:0] area_length;
   } item_type;

endpackage

[rtl/tcpo_req_if.sv]
// ---------------------------------------------------------------------------
// Option byte channel
// Valid/ready channel carrying one byte of a TCP option area.
// ---------------------------------------------------------------------------
interface tcpo_req_if;
   import tcpo_pkg::*;

   logic              valid;
   logic              ready;
   logic [7:0]        data_byte;
   logic              first_byte;
   logic [AREA_W-1:0] area_length;

   modport source (output valid, output data_byte, output first_byte,
                   output area_length, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input area_length, output ready);
endinterface

[rtl/tcpo_rsp_if.sv]
// ---------------------------------------------------------------------------
// Option result channel
// Valid/ready channel carrying one decoded option result.
// ---------------------------------------------------------------------------
interface tcpo_rsp_if;
   import tcpo_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind_code;
   logic [VALUE_W-1:0] value_a;
   logic [VALUE_W-1:0] value_b;
   logic               last_result;

   modport source (output valid, output kind_code, output value_a, output value_b,
                   output last_result, input ready);
   modport sink   (input valid, input kind_code, input value_a, input value_b,
                   input last_result, output ready);
endinterface

[rtl/tcp_option_parser_core.sv]
// ---------------------------------------------------------------------------
// TCP option parser core
// Streaming decoder for the option area of a TCP header, one byte a cycle while the result queue has room.
// ---------------------------------------------------------------------------
// The core takes one option byte per cycle on req_chan and delivers decoded
// results on rsp_chan. A byte is registered, decoded by one pass of logic
// against the parser state and its results written into a four-entry result
// queue that rsp_chan reads. The input accepts a byte every cycle while the
// queue has room for two results; the final byte of an area can give an
// option or error result plus the done result, and the queue drains one
// result per cycle, so a stalled or slow rsp_chan is what throttles the
// input.
module tcp_option_parser_core #(
   parameter int MAX_AREA_BYTES = 40
) (
   input  logic       clock,
   input  logic       reset,
   tcpo_req_if.sink   req_chan,
   tcpo_rsp_if.source rsp_chan
);
   import tcpo_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Input register
   logic     in_vld_ff, in_vld_in;
   item_type in_ff;

   // Parser state
   phase_type         phase_ff, phase_in;
   logic [AREA_W-1:0] area_left_ff, area_left_in;
   kind_type          kind_ff, kind_in;
   logic [AREA_W-1:0] opt_left_ff, opt_left_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [2:0]        sack_cnt_ff, sack_cnt_in;
   logic              err_ff, err_in;

   // Result queue
   result_type        q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic req_acc, proc_go, pop, live;

   // Working state after first-byte restart
   phase_type         eff_phase;
   kind_type          eff_kind;
   logic [AREA_W-1:0] eff_opt;
   logic [ACC_W-1:0]  eff_acc;
   logic [2:0]        eff_cnt;
   logic              eff_err;
   logic [AREA_W-1:0] alen_adj, rem;

   logic [ACC_W-1:0]  acc_shift;
   logic [AREA_W-1:0] opt_dec, area_dec, body;
   logic [2:0]        cnt_inc;
   logic              area_end, sack_len_bad, body_bad;
   logic [7:0]        byte_v;

   // Results of this byte
   logic       op_vld;
   result_type op_res, done_res, r0, r1;
   logic [1:0] push_n;

   assign byte_v  = in_ff.data_byte;
   assign proc_go = in_vld_ff && (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_chan.ready = !in_vld_ff || proc_go;
   assign req_acc = req_chan.valid && req_chan.ready;
   assign pop     = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      if (in_ff.area_length == '0) begin
         alen_adj = AREA_W'(1);
      end else if (in_ff.area_length > AREA_W'(MAX_AREA_BYTES)) begin
         alen_adj = AREA_W'(MAX_AREA_BYTES);
      end else begin
         alen_adj = in_ff.area_length;
      end
   end

   always_comb begin
      if (in_ff.first_byte) begin
         eff_phase = PH_KIND;
         eff_kind  = K_EOL;
         eff_opt   = '0;
         eff_acc   = '0;
         eff_cnt   = '0;
         eff_err   = 1'b0;
         rem       = alen_adj;
      end else begin
         eff_phase = phase_ff;
         eff_kind  = kind_ff;
         eff_opt   = opt_left_ff;
         eff_acc   = acc_ff;
         eff_cnt   = sack_cnt_ff;
         eff_err   = err_ff;
         rem       = area_left_ff;
      end
   end

   assign live         = in_ff.first_byte || (area_left_ff != '0);
   assign acc_shift    = {eff_acc[ACC_W-9:0], byte_v};
   assign opt_dec      = eff_opt - AREA_W'(1);
   assign cnt_inc      = eff_cnt + 3'd1;
   assign area_dec     = rem - AREA_W'(1);
   assign area_end     = (area_dec == '0);
   assign sack_len_bad = (byte_v < 8'(LEN_HDR)) ||
                         ({1'b0, byte_v} > ({3'b0, rem} + 9'd1));
   assign body         = AREA_W'(byte_v - 8'(LEN_HDR));
   assign body_bad     = (body == '0) || (body[2:0] != 3'd0);

   // Next state
   always_comb begin
      phase_in     = eff_phase;
      kind_in      = eff_kind;
      opt_left_in  = eff_opt;
      acc_in       = eff_acc;
      sack_cnt_in  = eff_cnt;
      err_in       = eff_err;
      area_left_in = area_dec;
      if (!eff_err) begin
         case (eff_phase)
            PH_KIND: begin
               case (byte_v)
                  OPT_EOL, OPT_NOP: begin
                  end
                  OPT_MSS, OPT_WSCALE, OPT_SACKOK, OPT_TSTAMP: begin
                     if (((byte_v == OPT_MSS) && (rem < LEN_MSS)) ||
                         ((byte_v == OPT_WSCALE) && (rem < LEN_WSCALE)) ||
                         ((byte_v == OPT_SACKOK) && (rem < LEN_SACKOK)) ||
                         ((byte_v == OPT_TSTAMP) && (rem < LEN_TSTAMP))) begin
                        err_in = 1'b1;
                     end else begin
                        phase_in = PH_SKIP_LEN;
                        acc_in   = '0;
                        case (byte_v)
                           OPT_MSS: begin
                              kind_in     = K_MSS;
                              opt_left_in = LEN_MSS - LEN_HDR;
                           end
                           OPT_WSCALE: begin
                              kind_in     = K_WSCALE;
                              opt_left_in = LEN_WSCALE - LEN_HDR;
                           end
                           OPT_SACKOK: begin
                              kind_in     = K_SACKOK;
                              opt_left_in = LEN_SACKOK - LEN_HDR;
                           end
                           default: begin
                              kind_in     = K_TSTAMP;
                              opt_left_in = LEN_TSTAMP - LEN_HDR;
                           end
                        endcase
                     end
                  end
                  OPT_SACK: begin
                     if (rem < LEN_HDR) begin
                        err_in = 1'b1;
                     end else begin
                        phase_in = PH_SACK_LEN;
                     end
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
            end
            PH_SKIP_LEN: begin
               if (eff_opt == '0) begin
                  phase_in = PH_KIND;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               acc_in      = acc_shift;
               opt_left_in = opt_dec;
               if (opt_dec == '0) begin
                  phase_in = PH_KIND;
               end
            end
            PH_SACK_LEN: begin
               if (sack_len_bad) begin
                  err_in = 1'b1;
               end else if (body_bad) begin
                  opt_left_in = body;
                  phase_in    = (body == '0) ? PH_KIND : PH_SACK_SKIP;
               end else begin
                  opt_left_in = body;
                  sack_cnt_in = '0;
                  acc_in      = '0;
                  phase_in    = PH_SACK_BLOCK;
               end
            end
            PH_SACK_BLOCK: begin
               acc_in      = (cnt_inc == 3'd0) ? '0 : acc_shift;
               sack_cnt_in = cnt_inc;
               opt_left_in = opt_dec;
               if (opt_dec == '0) begin
                  phase_in = PH_KIND;
               end
            end
            PH_SACK_SKIP: begin
               opt_left_in = opt_dec;
               if (opt_dec == '0) begin
                  phase_in = PH_KIND;
               end
            end
            default: begin
               phase_in = PH_KIND;
            end
         endcase
         // Errors park the parser on the kind phase
         if (err_in) begin
            phase_in = PH_KIND;
         end
      end
      if (area_end) begin
         phase_in = PH_KIND;
         err_in   = 1'b0;
      end
   end

   // Results
   always_comb begin
      op_vld = 1'b0;
      op_res = '{kind_code: K_EOL, value_a: '0, value_b: '0, last_result: 1'b0};
      if (!eff_err) begin
         case (eff_phase)
            PH_KIND: begin
               op_vld = 1'b1;
               case (byte_v)
                  OPT_EOL: op_res.kind_code = K_EOL;
                  OPT_NOP: op_res.kind_code = K_NOP;
                  OPT_MSS: begin
                     op_vld = (rem < LEN_MSS);
                     op_res.kind_code = K_TRUNCATED;
                  end
                  OPT_WSCALE: begin
                     op_vld = (rem < LEN_WSCALE);
                     op_res.kind_code = K_TRUNCATED;
                  end
                  OPT_SACKOK: begin
                     op_vld = (rem < LEN_SACKOK);
                     op_res.kind_code = K_TRUNCATED;
                  end
                  OPT_TSTAMP: begin
                     op_vld = (rem < LEN_TSTAMP);
                     op_res.kind_code = K_TRUNCATED;
                  end
                  OPT_SACK: begin
                     op_vld = (rem < LEN_HDR);
                     op_res.kind_code = K_TRUNCATED;
                  end
                  default: op_res.kind_code = K_UNKNOWN;
               endcase
            end
            PH_SKIP_LEN: begin
               op_vld = (eff_opt == '0);
               op_res.kind_code = eff_kind;
            end
            PH_VALUE: begin
               op_vld = (opt_dec == '0);
               case (eff_kind)
                  K_MSS: begin
                     op_res.kind_code = K_MSS;
                     op_res.value_a   = {16'd0, acc_shift[15:0]};
                  end
                  K_WSCALE: begin
                     op_res.kind_code = K_WSCALE;
                     op_res.value_a   = {24'd0, acc_shift[7:0]};
                  end
                  default: begin
                     op_res.kind_code = K_TSTAMP;
                     op_res.value_a   = acc_shift[ACC_W-1:VALUE_W];
                     op_res.value_b   = acc_shift[VALUE_W-1:0];
                  end
               endcase
            end
            PH_SACK_LEN: begin
               op_vld = 1'b1;
               if (sack_len_bad) begin
                  op_res.kind_code = K_TRUNCATED;
               end else if (body_bad) begin
                  op_res.kind_code = K_SACK_BAD;
               end else begin
                  op_res.kind_code = K_SACK_HDR;
                  op_res.value_a   = VALUE_W'(body[AREA_W-1:3]);
               end
            end
            PH_SACK_BLOCK: begin
               op_vld = (cnt_inc == 3'd0);
               op_res.kind_code = K_SACK_BLOCK;
               op_res.value_a   = acc_shift[ACC_W-1:VALUE_W];
               op_res.value_b   = acc_shift[VALUE_W-1:0];
            end
            PH_SACK_SKIP: begin
               op_vld = 1'b0;
            end
            default: begin
               op_vld = 1'b0;
            end
         endcase
      end
   end

   assign done_res = '{kind_code: K_DONE, value_a: '0, value_b: '0, last_result: 1'b1};

   always_comb begin
      r1 = done_res;
      if (!(proc_go && live)) begin
         push_n = 2'd0;
         r0     = done_res;
      end else if (op_vld) begin
         push_n = area_end ? 2'd2 : 2'd1;
         r0     = op_res;
      end else begin
         push_n = area_end ? 2'd1 : 2'd0;
         r0     = done_res;
      end
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_acc) begin
         in_vld_in = 1'b1;
      end else if (proc_go) begin
         in_vld_in = 1'b0;
      end
   end

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         phase_ff     <= PH_KIND;
         area_left_ff <= '0;
         kind_ff      <= K_EOL;
         opt_left_ff  <= '0;
         acc_ff       <= '0;
         sack_cnt_ff  <= '0;
         err_ff       <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         // Advance parser state only on a byte inside an area
         if (proc_go && live) begin
            phase_ff     <= phase_in;
            area_left_ff <= area_left_in;
            kind_ff      <= kind_in;
            opt_left_ff  <= opt_left_in;
            acc_ff       <= acc_in;
            sack_cnt_ff  <= sack_cnt_in;
            err_ff       <= err_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_ff.data_byte   <= req_chan.data_byte;
         in_ff.first_byte  <= req_chan.first_byte;
         in_ff.area_length <= req_chan.area_length;
      end
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= r0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + QPTR_W'(1)] <= r1;
      end
   end

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.kind_code   = q_ff[rd_ptr_ff].kind_code;
   assign rsp_chan.value_a     = q_ff[rd_ptr_ff].value_a;
   assign rsp_chan.value_b     = q_ff[rd_ptr_ff].value_b;
   assign rsp_chan.last_result = q_ff[rd_ptr_ff].last_result;

`include "assert_macros.svh"

   `TCPO_ASSERT(a_queue_bound, count_ff <= QCNT_W'(QDEPTH), "result queue overflow")
   `TCPO_ASSERT(a_err_parks, err_ff |-> (phase_ff == PH_KIND), "error not parked on kind phase")
   `TCPO_ASSERT(a_last_is_done, (rsp_chan.valid && rsp_chan.last_result) |-> (rsp_chan.kind_code == K_DONE), "last flag on a non-done result")
   `TCPO_ASSERT_NEVER(a_area_bound, area_left_ff > AREA_W'(MAX_AREA_BYTES), "area count above limit")

endmodule
